[sv/ibls_pkg.sv]
// package for the image border line scanner: constants, register indexes and shared types
`timescale 1ns / 1ps

package ibls_pkg;

    localparam int PIX_BITS   = 8;
    localparam int COUNT_BITS = 13;
    localparam int MARGIN_BITS = 12;
    localparam int WIDTH_BITS = 13;
    localparam int CFG_DATA_BITS = 12;
    localparam int CFG_INDEX_BITS = 2;
    localparam int SUM_BITS = ((COUNT_BITS > MARGIN_BITS) ? COUNT_BITS : MARGIN_BITS) + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [PIX_BITS-1:0]    RANGE_THR_RESET = 8'd26;
    localparam logic [PIX_BITS-1:0]    STEP_THR_RESET  = 8'd10;
    localparam logic [MARGIN_BITS-1:0] MARGIN_RESET    = 12'd4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_RANGE_THR = 2'd0,
        REG_STEP_THR  = 2'd1,
        REG_MARGIN    = 2'd2
    } cfg_index_t;

    // line measurements including the pixel being taken
    typedef struct packed {
        logic [PIX_BITS-1:0] step;
        logic [PIX_BITS-1:0] range;
    } line_stat_t;

endpackage

[sv/image_border_line_scanner_core.sv]
// image border line scanner top level: border counting, configuration and result register
//
// usage:
//   pixels enter on the s_ channel in scan order, one transfer per pixel, with
//   s_line_end on the last pixel of a line and s_scan_end on the last pixel of
//   the scan (scan end also closes the line). each closed line yields one
//   result on the m_ channel: border width so far (margin plus border lines,
//   saturating), the line's content flag, whether content was seen in this
//   scan, and the scan-done flag. pixels that do not close a line give nothing.
//   a result is registered and valid the cycle after the closing pixel's transfer.
//   throughput: one pixel per cycle; the per-pixel compare and subtract work
//   sits between the line state registers and the result register.
//   when the receiver stalls, the result register holds; pixels that do not
//   close a line are still taken, a line-closing pixel waits for the slot.
//   reset (aresetn low, synchronous) restores default thresholds and margin
//   and clears the scan. configuration is written through cfg_wr_en,
//   cfg_wr_index and cfg_wr_data while the block is idle.
`timescale 1ns / 1ps

module image_border_line_scanner_core
    import ibls_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_wr_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [PIX_BITS-1:0]       s_pixel,
    input  logic                      s_line_end,
    input  logic                      s_scan_end,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [WIDTH_BITS-1:0]     m_border_width,
    output logic                      m_line_is_content,
    output logic                      m_found_content,
    output logic                      m_scan_done
);

    logic [PIX_BITS-1:0]    range_thr_reg;
    logic [PIX_BITS-1:0]    step_thr_reg;
    logic [MARGIN_BITS-1:0] margin_reg;

    logic [COUNT_BITS-1:0]  border_lines_reg, border_lines_next;
    logic                   content_seen_reg, content_seen_next;

    logic                   m_valid_reg;
    logic [WIDTH_BITS-1:0]  width_reg;
    logic                   content_reg;
    logic                   found_reg;
    logic                   done_reg;

    logic                   line_done;
    logic                   accept;
    logic                   content;
    logic [SUM_BITS-1:0]    width_sum;
    logic [SUM_BITS-1:0]    width_sat;
    line_stat_t             stat;

    assign line_done = s_line_end | s_scan_end;
    assign s_ready   = !m_valid_reg || m_ready || !line_done;
    assign accept    = s_valid && s_ready;

    ibls_line_stats u_stats (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (accept),
        .pixel     (s_pixel),
        .line_last (line_done),
        .stat      (stat)
    );

    always_comb begin
        content = (stat.step > step_thr_reg) && (stat.range > range_thr_reg);
        border_lines_next = border_lines_reg;
        content_seen_next = content_seen_reg;
        if (!content_seen_reg) begin
            if (content) begin
                content_seen_next = 1'b1;
            end else if (border_lines_reg < COUNT_MAX) begin
                border_lines_next = border_lines_reg + COUNT_BITS'(1);
            end
        end
        width_sum = SUM_BITS'(margin_reg) + SUM_BITS'(border_lines_next);
        width_sat = (width_sum > SUM_BITS'(COUNT_MAX)) ? SUM_BITS'(COUNT_MAX) : width_sum;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_thr_reg <= RANGE_THR_RESET;
            step_thr_reg  <= STEP_THR_RESET;
            margin_reg    <= MARGIN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                REG_RANGE_THR: range_thr_reg <= cfg_wr_data[PIX_BITS-1:0];
                REG_STEP_THR:  step_thr_reg  <= cfg_wr_data[PIX_BITS-1:0];
                REG_MARGIN:    margin_reg    <= cfg_wr_data[MARGIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            border_lines_reg <= '0;
            content_seen_reg <= 1'b0;
        end else if (accept && line_done) begin
            if (s_scan_end) begin
                border_lines_reg <= '0;
                content_seen_reg <= 1'b0;
            end else begin
                border_lines_reg <= border_lines_next;
                content_seen_reg <= content_seen_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && line_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && line_done) begin
            width_reg   <= WIDTH_BITS'(width_sat);
            content_reg <= content;
            found_reg   <= content_seen_next;
            done_reg    <= s_scan_end;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_border_width    = width_reg;
    assign m_line_is_content = content_reg;
    assign m_found_content   = found_reg;
    assign m_scan_done       = done_reg;

`ifndef SYNTH
    a_count_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (content_seen_reg && !(accept && s_scan_end)) |=> $stable(border_lines_reg))
        else $error("border count moved after content was found");
    a_content_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_line_is_content) |-> m_found_content)
        else $error("content line reported without found flag");
    a_scan_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_scan_end) |=> (!content_seen_reg && (border_lines_reg == '0)))
        else $error("scan state not cleared after scan end");
    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && line_done) |=> (m_valid && (m_scan_done == $past(s_scan_end))))
        else $error("line end transfer did not load a result");
`endif

endmodule

[sv/ibls_line_stats.sv]
// per-line minimum, maximum and largest adjacent step tracker
`timescale 1ns / 1ps

module ibls_line_stats
    import ibls_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  logic [PIX_BITS-1:0] pixel,
    input  logic                line_last,
    output line_stat_t          stat
);

    logic [PIX_BITS-1:0] min_reg, min_next;
    logic [PIX_BITS-1:0] max_reg, max_next;
    logic [PIX_BITS-1:0] step_reg, step_next;
    logic [PIX_BITS-1:0] prev_reg;
    logic                at_start_reg;
    logic [PIX_BITS-1:0] diff;

    always_comb begin
        diff = (pixel > prev_reg) ? (pixel - prev_reg) : (prev_reg - pixel);
        if (at_start_reg) begin
            // first pixel of a line is never compared with the previous one
            min_next  = pixel;
            max_next  = pixel;
            step_next = '0;
        end else begin
            min_next  = (pixel < min_reg) ? pixel : min_reg;
            max_next  = (pixel > max_reg) ? pixel : max_reg;
            step_next = (diff > step_reg) ? diff : step_reg;
        end
        stat.step  = step_next;
        stat.range = max_next - min_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg      <= '1;
            max_reg      <= '0;
            step_reg     <= '0;
            prev_reg     <= '0;
            at_start_reg <= 1'b1;
        end else if (take) begin
            if (line_last) begin
                min_reg      <= '1;
                max_reg      <= '0;
                step_reg     <= '0;
                prev_reg     <= '0;
                at_start_reg <= 1'b1;
            end else begin
                min_reg      <= min_next;
                max_reg      <= max_next;
                step_reg     <= step_next;
                prev_reg     <= pixel;
                at_start_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        !at_start_reg |-> (min_reg <= max_reg))
        else $error("line minimum above line maximum");
`endif

endmodule
